[hw/rtl/pdsr_pkg.sv]
// Shared constants and types for the polyline degenerate span removal block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package pdsr_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int TOL_WIDTH       = 52;
  localparam int CFG_IDX_WIDTH   = 1;
  localparam int QDEPTH          = 4;
  localparam int QPTR_WIDTH      = $clog2(QDEPTH);
  localparam int QCNT_WIDTH      = $clog2(QDEPTH + 1);

  // configuration register indexes
  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_THREE_D_MODE      = 1'b0,
    REG_TOLERANCE_SQUARED = 1'b1
  } pdsr_reg_t;

  // words pushed into the result queue in one cycle; second implies first
  typedef struct packed {
    logic first;
    logic second;
  } pdsr_push_t;

endpackage

[hw/rtl/polyline_degenerate_span_removal.sv]
// Polyline degenerate span removal, top level: drops points within tolerance
// of the last kept point. A point is taken into an input register, tested and
// written to a four-word result queue, so the sustained rate is one point per
// cycle while not stalled; the path that sets the clock is difference, square,
// sum and compare against the held point, which loops back into the held
// point. Results trail the input by one point since the last kept point is
// held back; a final point may give two result words, queued in the same
// cycle. in_stall rises only when the queue has room for fewer than two words.
// The user must write configuration only while idle; the block does not check.
// Depends on pdsr_pkg, pdsr_core and pdsr_outq.
`timescale 1ns / 1ps
module polyline_degenerate_span_removal
  import pdsr_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_WIDTH-1:0]      cfg_index,
  input  logic [TOL_WIDTH-1:0]          cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_x_coord,
  input  logic signed [COORD_WIDTH-1:0] in_y_coord,
  input  logic signed [COORD_WIDTH-1:0] in_z_coord,
  input  logic                          in_is_last_point,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic signed [COORD_WIDTH-1:0] out_z,
  output logic                          out_last_output,
  output logic [COUNT_WIDTH-1:0]        out_degenerate_count
);

  localparam int EW = 3 * COORD_WIDTH + 1 + COUNT_WIDTH;

  pdsr_push_t    push;
  logic [EW-1:0] res0, res1, out_word;
  logic          room2;

  pdsr_core #(
    .COORD_WIDTH (COORD_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_x_coord       (in_x_coord),
    .in_y_coord       (in_y_coord),
    .in_z_coord       (in_z_coord),
    .in_is_last_point (in_is_last_point),
    .room2            (room2),
    .push             (push),
    .res0             (res0),
    .res1             (res1)
  );

  pdsr_outq #(
    .EW (EW)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .res0      (res0),
    .res1      (res1),
    .room2     (room2),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  assign out_x                = out_word[EW-1 -: COORD_WIDTH];
  assign out_y                = out_word[EW-1-COORD_WIDTH -: COORD_WIDTH];
  assign out_z                = out_word[EW-1-2*COORD_WIDTH -: COORD_WIDTH];
  assign out_last_output      = out_word[COUNT_WIDTH];
  assign out_degenerate_count = out_word[COUNT_WIDTH-1:0];

endmodule

[hw/rtl/pdsr_core.sv]
// Input register, configuration registers, span test and polyline state.
// Depends on pdsr_pkg; feeds up to two result words per point to pdsr_outq.
`timescale 1ns / 1ps
module pdsr_core
  import pdsr_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  localparam int EW = 3 * COORD_WIDTH + 1 + COUNT_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_WIDTH-1:0]      cfg_index,
  input  logic [TOL_WIDTH-1:0]          cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_x_coord,
  input  logic signed [COORD_WIDTH-1:0] in_y_coord,
  input  logic signed [COORD_WIDTH-1:0] in_z_coord,
  input  logic                          in_is_last_point,
  input  logic                          room2,
  output pdsr_push_t                    push,
  output logic [EW-1:0]                 res0,
  output logic [EW-1:0]                 res1
);

  localparam int CW   = COORD_WIDTH;
  localparam int SQW  = 2 * (CW + 1);
  localparam int SUMW = SQW + 2;
  localparam int CMPW = (SUMW > TOL_WIDTH) ? SUMW : TOL_WIDTH;

  // configuration
  logic                 three_d_r;
  logic [TOL_WIDTH-1:0] tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      three_d_r <= 1'b1;
      tol_r     <= '0;
    end else if (cfg_we) begin
      unique case (pdsr_reg_t'(cfg_index))
        REG_THREE_D_MODE:      three_d_r <= cfg_wdata[0];
        REG_TOLERANCE_SQUARED: tol_r     <= cfg_wdata;
      endcase
    end
  end

  // input register
  logic          ir_valid_r, ir_valid_nxt;
  logic [CW-1:0] ir_x_r, ir_y_r, ir_z_r;
  logic          ir_last_r;
  logic          accept, go;

  assign go       = ir_valid_r & room2;
  assign in_stall = ir_valid_r & ~room2;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    ir_valid_nxt = ir_valid_r;
    if (accept) begin
      ir_valid_nxt = 1'b1;
    end else if (go) begin
      ir_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ir_valid_r <= 1'b0;
    end else begin
      ir_valid_r <= ir_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ir_x_r    <= in_x_coord;
      ir_y_r    <= in_y_coord;
      ir_z_r    <= in_z_coord;
      ir_last_r <= in_is_last_point;
    end
  end

  // polyline state
  logic                   holding_r, holding_nxt;
  logic                   only_first_r, only_first_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0]          held_x_r, held_y_r, held_z_r;
  logic                   load_held;

  // span test: exact squared distance to the held point
  logic [CW:0]     dx, dy, dz, mx, my, mz;
  logic [SQW-1:0]  sqx, sqy, sqz;
  logic [SUMW-1:0] d2;
  logic            degen;
  logic [COUNT_WIDTH-1:0] cnt_inc;

  assign dx = {ir_x_r[CW-1], ir_x_r} - {held_x_r[CW-1], held_x_r};
  assign dy = {ir_y_r[CW-1], ir_y_r} - {held_y_r[CW-1], held_y_r};
  assign dz = {ir_z_r[CW-1], ir_z_r} - {held_z_r[CW-1], held_z_r};
  assign mx = dx[CW] ? (~dx + 1'b1) : dx;
  assign my = dy[CW] ? (~dy + 1'b1) : dy;
  assign mz = dz[CW] ? (~dz + 1'b1) : dz;
  assign sqx = SQW'(mx) * SQW'(mx);
  assign sqy = SQW'(my) * SQW'(my);
  assign sqz = SQW'(mz) * SQW'(mz);
  assign d2 = SUMW'(sqx) + SUMW'(sqy) + (three_d_r ? SUMW'(sqz) : SUMW'(0));
  assign degen = holding_r & (CMPW'(d2) <= CMPW'(tol_r));
  assign cnt_inc = (degen && cnt_r != '1) ? cnt_r + 1'b1 : cnt_r;

  // result words
  logic          emit_held;
  logic [CW-1:0] out_zin, out_zheld;
  logic [EW-1:0] held_word, final_word;

  assign emit_held  = holding_r & (ir_last_r ? (~degen | only_first_r) : ~degen);
  assign out_zin    = three_d_r ? ir_z_r : '0;
  assign out_zheld  = three_d_r ? held_z_r : '0;
  assign held_word  = {held_x_r, held_y_r, out_zheld, 1'b0, {COUNT_WIDTH{1'b0}}};
  assign final_word = {ir_x_r, ir_y_r, out_zin, 1'b1, cnt_inc};

  assign res0        = emit_held ? held_word : final_word;
  assign res1        = final_word;
  assign push.first  = go & (emit_held | ir_last_r);
  assign push.second = go & emit_held & ir_last_r;

  always_comb begin
    holding_nxt    = holding_r;
    only_first_nxt = only_first_r;
    cnt_nxt        = cnt_r;
    load_held      = 1'b0;
    if (go) begin
      if (ir_last_r) begin
        holding_nxt    = 1'b0;
        only_first_nxt = 1'b1;
        cnt_nxt        = '0;
      end else if (!holding_r) begin
        holding_nxt    = 1'b1;
        only_first_nxt = 1'b1;
        cnt_nxt        = '0;
        load_held      = 1'b1;
      end else begin
        cnt_nxt = cnt_inc;
        if (!degen) begin
          only_first_nxt = 1'b0;
          load_held      = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      holding_r    <= 1'b0;
      only_first_r <= 1'b1;
      cnt_r        <= '0;
    end else begin
      holding_r    <= holding_nxt;
      only_first_r <= only_first_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_held) begin
      held_x_r <= ir_x_r;
      held_y_r <= ir_y_r;
      held_z_r <= ir_z_r;
    end
  end

`ifndef ASSERT_OFF
  // a final point always closes the polyline
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    go && ir_last_r |=> !holding_r && only_first_r && cnt_r == '0)
    else $error("final point did not clear polyline state");

  // count only moves while a polyline is open
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !holding_r |-> cnt_r == '0)
    else $error("degenerate count nonzero with no point held");

  // a held word never leaves before a polyline is open
  a_held_open: assert property (@(posedge clk) disable iff (!rst_n)
    emit_held |-> holding_r)
    else $error("held point emitted with nothing held");
`endif

endmodule

[hw/rtl/pdsr_outq.sv]
// Small result queue: takes up to two words a cycle, hands out one while out_stall is low.
// Depends on pdsr_pkg for depth and push flags.
`timescale 1ns / 1ps
module pdsr_outq
  import pdsr_pkg::*;
#(
  parameter int EW = 3 * COORD_WIDTH_DEF + 1 + COUNT_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  pdsr_push_t    push,
  input  logic [EW-1:0] res0,
  input  logic [EW-1:0] res1,
  output logic          room2,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [EW-1:0] out_word
);

  logic [EW-1:0]         q_r [QDEPTH];
  logic [QPTR_WIDTH-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_WIDTH-1:0] count_r, count_nxt;
  logic                  pop;
  logic [QPTR_WIDTH-1:0] wr_ptr_p1;

  assign out_valid = count_r != '0;
  assign out_word  = q_r[rd_ptr_r];
  assign pop       = out_valid & ~out_stall;
  assign room2     = count_r <= QCNT_WIDTH'(QDEPTH - 2);
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (push.second) begin
      wr_ptr_nxt = wr_ptr_r + QPTR_WIDTH'(2);
    end else if (push.first) begin
      wr_ptr_nxt = wr_ptr_p1;
    end
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCNT_WIDTH'(push.first) + QCNT_WIDTH'(push.second)
                 - QCNT_WIDTH'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.first) begin
      q_r[wr_ptr_r] <= res0;
    end
    if (push.second) begin
      q_r[wr_ptr_p1] <= res1;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_WIDTH'(QDEPTH))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.first |-> room2)
    else $error("push without room for two words");

  a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.second |-> push.first)
    else $error("second word pushed without first");
`endif

endmodule
